@@ src/qcsv_pkg.sv @@
// Package for the quoted CSV record parser.
// Holds the token type, parse-state and status codes, and shared constants.
// No dependencies.
`default_nettype none

package qcsv_pkg;

    localparam int QCSV_NUMBER_WIDTH = 31;
    localparam int QCSV_FIFO_DEPTH   = 2;
    localparam int QCSV_ADDR_WIDTH   = 3;
    localparam int QCSV_DATA_WIDTH   = 32;

    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] SEP_RESET     = 8'd44;
    localparam logic [7:0] QUOTE_RESET   = 8'd34;

    localparam logic CFG_SEPARATOR = 1'b0;
    localparam logic CFG_QUOTE     = 1'b1;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_RANK   = 4'd1,
        ST_QNAME  = 4'd2,
        ST_NAME   = 4'd3,
        ST_SEP2   = 4'd4,
        ST_QPOP   = 4'd5,
        ST_POP    = 4'd6,
        ST_ACCEPT = 4'd10,
        ST_ERROR  = 4'd11
    } qcsv_state_t;

    typedef enum logic [1:0] {
        STATUS_BUSY     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_ERROR    = 2'd2
    } qcsv_status_t;

    typedef struct packed {
        logic       line_start;
        logic       is_digit;
        logic       is_sep;
        logic       is_quote;
        logic [3:0] digit;
        logic [7:0] char_byte;
    } qcsv_token_t;

endpackage

`default_nettype wire

@@ src/qcsv_front.sv @@
// Front end: configuration registers on the APB port and byte classification.
// Depends on qcsv_pkg.
`default_nettype none

module qcsv_front
    import qcsv_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [QCSV_ADDR_WIDTH-1:0] paddr,
    input  wire logic [QCSV_DATA_WIDTH-1:0] pwdata,
    output logic      [QCSV_DATA_WIDTH-1:0] prdata,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       line_start,
    output qcsv_token_t                     token
);

    logic [7:0] sep_reg;
    logic [7:0] quote_reg;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg   <= SEP_RESET;
            quote_reg <= QUOTE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == CFG_SEPARATOR) begin
                sep_reg <= pwdata[7:0];
            end else begin
                quote_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_QUOTE) begin
            prdata = QCSV_DATA_WIDTH'(quote_reg);
        end else begin
            prdata = QCSV_DATA_WIDTH'(sep_reg);
        end
    end

    always_comb begin
        token.line_start = line_start;
        token.is_digit   = (in_byte inside {[CHAR_ZERO:CHAR_NINE]});
        token.is_sep     = (in_byte == sep_reg);
        token.is_quote   = (in_byte == quote_reg);
        token.digit      = 4'(in_byte - CHAR_ZERO);
        token.char_byte  = in_byte;
    end

endmodule

`default_nettype wire

@@ src/qcsv_fifo.sv @@
// Short token queue between the front end and the parse engine.
// Depends on qcsv_pkg.
`default_nettype none

module qcsv_fifo
    import qcsv_pkg::*;
#(
    parameter int DEPTH = QCSV_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire qcsv_token_t push_tok,
    output logic             full,
    input  wire logic        pop,
    output qcsv_token_t      pop_tok,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qcsv_token_t         mem_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_tok = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/qcsv_back.sv @@
// Parse engine: record state machine, saturating decimal accumulator and
// result register. Depends on qcsv_pkg.
`default_nettype none

module qcsv_back
    import qcsv_pkg::*;
#(
    parameter int NUMBER_WIDTH = QCSV_NUMBER_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    tok_avail,
    input  wire qcsv_token_t             tok,
    output logic                         tok_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_status,
    output logic [7:0]                   m_name_byte,
    output logic                         m_name_valid,
    output logic                         m_name_end,
    output logic [NUMBER_WIDTH-1:0]      m_rank_value,
    output logic                         m_rank_valid,
    output logic [NUMBER_WIDTH-1:0]      m_population_value,
    output logic                         m_population_valid
);

    localparam int SW = NUMBER_WIDTH + 4;
    localparam logic [NUMBER_WIDTH-1:0] ACC_MAX = '1;

    qcsv_state_t              state_reg, state_next;
    logic [NUMBER_WIDTH-1:0]  acc_reg, acc_next;
    logic [NUMBER_WIDTH-1:0]  acc_cur;
    qcsv_state_t              state_cur;
    logic [SW-1:0]            acc_ext;
    logic [SW-1:0]            acc_sum;
    logic [NUMBER_WIDTH-1:0]  acc_dig;

    logic                     out_valid_reg;
    qcsv_status_t             status_reg, status_next;
    logic [7:0]               name_byte_reg, name_byte_next;
    logic                     name_valid_reg, name_valid_next;
    logic                     name_end_reg, name_end_next;
    logic [NUMBER_WIDTH-1:0]  rank_value_reg, rank_value_next;
    logic                     rank_valid_reg, rank_valid_next;
    logic [NUMBER_WIDTH-1:0]  pop_value_reg, pop_value_next;
    logic                     pop_valid_reg, pop_valid_next;

    assign tok_pop = tok_avail && (!out_valid_reg || m_ready);

    always_comb begin
        state_cur = tok.line_start ? ST_START : state_reg;
        acc_cur   = tok.line_start ? '0 : acc_reg;
        acc_ext   = SW'(acc_cur);
        acc_sum   = (acc_ext << 3) + (acc_ext << 1) + SW'(tok.digit);
        acc_dig   = (acc_sum[SW-1:NUMBER_WIDTH] != '0) ? ACC_MAX
                                                      : acc_sum[NUMBER_WIDTH-1:0];
    end

    always_comb begin
        state_next      = state_cur;
        acc_next        = acc_cur;
        name_byte_next  = '0;
        name_valid_next = 1'b0;
        name_end_next   = 1'b0;
        rank_value_next = '0;
        rank_valid_next = 1'b0;
        pop_value_next  = '0;
        pop_valid_next  = 1'b0;
        case (state_cur)
            ST_START: begin
                if (tok.is_digit) begin
                    acc_next   = acc_dig;
                    state_next = ST_RANK;
                end else begin
                    state_next = ST_ERROR;
                end
            end
            ST_RANK: begin
                if (tok.is_digit) begin
                    acc_next = acc_dig;
                end else if (tok.is_sep) begin
                    rank_value_next = acc_cur;
                    rank_valid_next = 1'b1;
                    acc_next        = '0;
                    state_next      = ST_QNAME;
                end else begin
                    state_next = ST_ERROR;
                end
            end
            ST_QNAME: begin
                state_next = tok.is_quote ? ST_NAME : ST_ERROR;
            end
            ST_NAME: begin
                if (tok.is_quote) begin
                    name_end_next = 1'b1;
                    state_next    = ST_SEP2;
                end else begin
                    name_byte_next  = tok.char_byte;
                    name_valid_next = 1'b1;
                end
            end
            ST_SEP2: begin
                state_next = tok.is_sep ? ST_QPOP : ST_ERROR;
            end
            ST_QPOP: begin
                state_next = tok.is_quote ? ST_POP : ST_ERROR;
            end
            ST_POP: begin
                if (tok.is_digit) begin
                    acc_next = acc_dig;
                end else if (tok.is_sep) begin
                    acc_next = acc_cur;
                end else if (tok.is_quote) begin
                    pop_value_next = acc_cur;
                    pop_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_ACCEPT;
                end
            end
            ST_ACCEPT: begin
                state_next = ST_ACCEPT;
            end
            default: begin
                state_next = ST_ERROR;
            end
        endcase
        case (state_next)
            ST_ACCEPT: status_next = STATUS_ACCEPTED;
            ST_ERROR:  status_next = STATUS_ERROR;
            default:   status_next = STATUS_BUSY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_START;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (tok_pop) begin
                state_reg     <= state_next;
                acc_reg       <= acc_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_pop) begin
            status_reg     <= status_next;
            name_byte_reg  <= name_byte_next;
            name_valid_reg <= name_valid_next;
            name_end_reg   <= name_end_next;
            rank_value_reg <= rank_value_next;
            rank_valid_reg <= rank_valid_next;
            pop_value_reg  <= pop_value_next;
            pop_valid_reg  <= pop_valid_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = status_reg;
    assign m_name_byte        = name_byte_reg;
    assign m_name_valid       = name_valid_reg;
    assign m_name_end         = name_end_reg;
    assign m_rank_value       = rank_value_reg;
    assign m_rank_valid       = rank_valid_reg;
    assign m_population_value = pop_value_reg;
    assign m_population_valid = pop_valid_reg;

endmodule

`default_nettype wire

@@ src/quoted_csv_record_parser.sv @@
// Channel   | Direction | Handshake            | Payload
// s_        | in        | s_valid / s_ready    | s_in_byte, s_line_start
// m_        | out       | m_valid / m_ready    | status, name, rank, population
// apb       | in        | psel, penable, pwrite| paddr, pwdata -> prdata, pready
//
// One byte per clock sustained while m_ready is held high; each transaction's result
// is registered first in the queue, then by an engine step into the result register.
// The token queue holds two entries, so input and output stall independently.
// aresetn is synchronous; it restores the comma and double-quote characters
// and returns the parser to its start state.
// Top level of the quoted CSV record parser. Depends on qcsv_pkg, qcsv_front,
// qcsv_fifo and qcsv_back.
`default_nettype none

module quoted_csv_record_parser
    import qcsv_pkg::*;
#(
    parameter int NUMBER_WIDTH = QCSV_NUMBER_WIDTH,
    parameter int FIFO_DEPTH   = QCSV_FIFO_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [QCSV_ADDR_WIDTH-1:0] paddr,
    input  wire logic [QCSV_DATA_WIDTH-1:0] pwdata,
    output logic      [QCSV_DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_in_byte,
    input  wire logic                       s_line_start,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_status,
    output logic [7:0]                      m_name_byte,
    output logic                            m_name_valid,
    output logic                            m_name_end,
    output logic [NUMBER_WIDTH-1:0]         m_rank_value,
    output logic                            m_rank_valid,
    output logic [NUMBER_WIDTH-1:0]         m_population_value,
    output logic                            m_population_valid
);

    qcsv_token_t in_tok;
    qcsv_token_t q_tok;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    assign pready  = 1'b1;
    assign s_ready = !q_full;

    qcsv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .in_byte    (s_in_byte),
        .line_start (s_line_start),
        .token      (in_tok)
    );

    qcsv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid),
        .push_tok (in_tok),
        .full     (q_full),
        .pop      (q_pop),
        .pop_tok  (q_tok),
        .empty    (q_empty)
    );

    qcsv_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .tok_avail          (!q_empty),
        .tok                (q_tok),
        .tok_pop            (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_name_byte        (m_name_byte),
        .m_name_valid       (m_name_valid),
        .m_name_end         (m_name_end),
        .m_rank_value       (m_rank_value),
        .m_rank_valid       (m_rank_valid),
        .m_population_value (m_population_value),
        .m_population_valid (m_population_valid)
    );

endmodule

`default_nettype wire

@@ src/qcsv_checker.sv @@
// Port-level checks for the quoted CSV record parser, bound to the top level.
// Depends on qcsv_pkg and quoted_csv_record_parser.
`default_nettype none

module qcsv_checker
    import qcsv_pkg::*;
#(
    parameter int NUMBER_WIDTH = QCSV_NUMBER_WIDTH
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [1:0]              m_status,
    input wire logic                    m_name_valid,
    input wire logic                    m_name_end,
    input wire logic                    m_rank_valid,
    input wire logic [NUMBER_WIDTH-1:0] m_rank_value,
    input wire logic                    m_population_valid
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_rank_value))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STATUS_BUSY || m_status == STATUS_ACCEPTED
                    || m_status == STATUS_ERROR)
        else $error("undefined status code");

    a_pop_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_population_valid |-> m_status == STATUS_ACCEPTED)
        else $error("population reported without acceptance");

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_name_valid, m_name_end, m_rank_valid,
                                m_population_valid}) <= 1)
        else $error("more than one field event in a transaction");

    a_name_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_name_valid || m_name_end || m_rank_valid)
            |-> m_status == STATUS_BUSY)
        else $error("field event with final status");

endmodule

bind quoted_csv_record_parser qcsv_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_qcsv_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_name_valid       (m_name_valid),
    .m_name_end         (m_name_end),
    .m_rank_valid       (m_rank_valid),
    .m_rank_value       (m_rank_value),
    .m_population_valid (m_population_valid)
);

`default_nettype wire
